// ===== hw/rtl/oblt_pkg.sv =====
// ----------------------------------------------------------------------------
// oblt_pkg
// Types and codes for the order book price-level table: request and response
// beats, stored level words, status codes and controller states.
// ----------------------------------------------------------------------------
package oblt_pkg;

    // request beat: one level update
    typedef struct packed {
        logic        side;
        logic [31:0] price;
        logic [31:0] qty;
    } req_t;

    // response beat: status and top of book after the update
    typedef struct packed {
        logic [2:0]  status;
        logic        bid_present;
        logic [31:0] best_bid_price;
        logic [31:0] best_bid_qty;
        logic        ask_present;
        logic [31:0] best_ask_price;
        logic [31:0] best_ask_qty;
    } rsp_t;

    // one stored level
    typedef struct packed {
        logic [31:0] price;
        logic [31:0] qty;
    } level_t;

    // side codes
    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    // status codes
    localparam logic [2:0] STATUS_UPDATED     = 3'd0;
    localparam logic [2:0] STATUS_REMOVED     = 3'd1;
    localparam logic [2:0] STATUS_INSERTED    = 3'd2;
    localparam logic [2:0] STATUS_ZERO_ABSENT = 3'd3;
    localparam logic [2:0] STATUS_FULL        = 3'd4;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_COMMIT
    } state_t;

endpackage

// ===== hw/rtl/order_book_level_table_core.sv =====
// ----------------------------------------------------------------------------
// order_book_level_table_core
// Price-level book with a bid and an ask side held in one level memory.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one level update (side, price, qty) per beat, taken when
//   req_valid is high and req_stall is low. rsp carries one beat per update:
//   a status code and the best bid (highest price) and best ask (lowest
//   price) after the update, with present bits and zero fields for an empty
//   side.
// Operation:
//   An update scans its side of the level memory one entry per cycle through
//   the single read port in S_SCAN, waits in S_LAST for the last read and
//   commits in S_COMMIT, which loads the response register; a new request is
//   taken only after that commit. The scan finds the matching level, the lowest
//   free entry and the best of the other levels; the commit writes or clears the
//   level and folds a written level into the kept best of that side.
// Reset:
//   rst_n clears all level valid bits and the kept best of both sides; the
//   book is empty and no clearing pass is needed.
// Stall:
//   A response held by rsp_stall stays in the output register; the next
//   update is still taken and scanned, and its commit waits for the register.
// ----------------------------------------------------------------------------
module order_book_level_table_core #(
    parameter int LEVELS_PER_SIDE = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  oblt_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output oblt_pkg::rsp_t  rsp
);

    localparam int IDX_W     = (LEVELS_PER_SIDE > 1) ? $clog2(LEVELS_PER_SIDE) : 1;
    localparam int ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LEVELS_PER_SIDE - 1);

    // price order of a side: bid wants higher, ask wants lower
    function automatic logic better(input logic side, input logic [31:0] a,
                                    input logic [31:0] b);
        logic res;
        begin
            if (side == oblt_pkg::SIDE_BID)
                res = (a > b);
            else
                res = (a < b);
            return res;
        end
    endfunction

    oblt_pkg::state_t state_reg, state_next;
    oblt_pkg::req_t   req_reg;

    // level memory and per-entry valid bits
    oblt_pkg::level_t mem [MEM_DEPTH];
    oblt_pkg::level_t mem_rdata_reg;
    logic [1:0][LEVELS_PER_SIDE-1:0] valid_reg;

    // scan pipeline
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_vld_reg;
    logic             rd_lvl_valid_reg;

    // scan accumulators
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             found_reg;
    logic [31:0]      bp_reg;
    logic [31:0]      bq_reg;

    // kept best per side
    logic [1:0]       best_present_reg;
    logic [1:0][31:0] best_price_reg;
    logic [1:0][31:0] best_qty_reg;

    // output register
    logic             rsp_valid_reg;
    oblt_pkg::rsp_t   rsp_reg;

    // control decode
    logic             req_take;
    logic             rd_issue;
    logic             commit_go;

    // commit decode
    logic [2:0]       status;
    logic             mem_we;
    logic [IDX_W-1:0] wr_idx;
    logic             set_valid;
    logic             clr_valid;
    logic             cand;
    logic             nb_present;
    logic [31:0]      nb_price;
    logic [31:0]      nb_qty;
    oblt_pkg::rsp_t   rsp_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oblt_pkg::S_IDLE:
            begin
                if (req_valid)
                    state_next = oblt_pkg::S_SCAN;
            end
            oblt_pkg::S_SCAN:
            begin
                if (rd_idx_reg == LAST_IDX)
                    state_next = oblt_pkg::S_LAST;
            end
            oblt_pkg::S_LAST:
            begin
                state_next = oblt_pkg::S_COMMIT;
            end
            oblt_pkg::S_COMMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                    state_next = oblt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = oblt_pkg::S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req_stall = 1'b1;
        rd_issue  = 1'b0;
        commit_go = 1'b0;
        case (state_reg)
            oblt_pkg::S_IDLE:   req_stall = 1'b0;
            oblt_pkg::S_SCAN:   rd_issue  = 1'b1;
            oblt_pkg::S_LAST:   req_stall = 1'b1;
            oblt_pkg::S_COMMIT: commit_go = !rsp_valid_reg || !rsp_stall;
            default:            req_stall = 1'b1;
        endcase
    end

    assign req_take = req_valid && !req_stall;

    // commit decision and new best for the updated side
    always_comb
    begin
        status    = oblt_pkg::STATUS_ZERO_ABSENT;
        mem_we    = 1'b0;
        wr_idx    = hit_idx_reg;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        cand      = 1'b0;
        if (hit_reg)
        begin
            if (req_reg.qty != 32'd0)
            begin
                status = oblt_pkg::STATUS_UPDATED;
                mem_we = commit_go;
                cand   = 1'b1;
            end
            else
            begin
                status    = oblt_pkg::STATUS_REMOVED;
                clr_valid = commit_go;
            end
        end
        else if (req_reg.qty == 32'd0)
        begin
            status = oblt_pkg::STATUS_ZERO_ABSENT;
        end
        else if (!free_found_reg)
        begin
            status = oblt_pkg::STATUS_FULL;
        end
        else
        begin
            status    = oblt_pkg::STATUS_INSERTED;
            wr_idx    = free_idx_reg;
            mem_we    = commit_go;
            set_valid = commit_go;
            cand      = 1'b1;
        end

        if (cand && (!found_reg || better(req_reg.side, req_reg.price, bp_reg)))
        begin
            nb_present = 1'b1;
            nb_price   = req_reg.price;
            nb_qty     = req_reg.qty;
        end
        else if (found_reg)
        begin
            nb_present = 1'b1;
            nb_price   = bp_reg;
            nb_qty     = bq_reg;
        end
        else
        begin
            nb_present = 1'b0;
            nb_price   = 32'd0;
            nb_qty     = 32'd0;
        end

        rsp_next.status = status;
        if (req_reg.side == oblt_pkg::SIDE_BID)
        begin
            rsp_next.bid_present    = nb_present;
            rsp_next.best_bid_price = nb_price;
            rsp_next.best_bid_qty   = nb_qty;
            rsp_next.ask_present    = best_present_reg[oblt_pkg::SIDE_ASK];
            rsp_next.best_ask_price = best_price_reg[oblt_pkg::SIDE_ASK];
            rsp_next.best_ask_qty   = best_qty_reg[oblt_pkg::SIDE_ASK];
        end
        else
        begin
            rsp_next.bid_present    = best_present_reg[oblt_pkg::SIDE_BID];
            rsp_next.best_bid_price = best_price_reg[oblt_pkg::SIDE_BID];
            rsp_next.best_bid_qty   = best_qty_reg[oblt_pkg::SIDE_BID];
            rsp_next.ask_present    = nb_present;
            rsp_next.best_ask_price = nb_price;
            rsp_next.best_ask_qty   = nb_qty;
        end
    end

    // level memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[{req_reg.side, wr_idx}] <= '{price: req_reg.price, qty: req_reg.qty};
        mem_rdata_reg <= mem[{req_reg.side, rd_idx_reg}];
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (req_take)
            req_reg <= req;
    end

    // controller, scan pipeline and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= oblt_pkg::S_IDLE;
            rd_idx_reg       <= '0;
            rd_vld_reg       <= 1'b0;
            rd_lvl_valid_reg <= 1'b0;
            valid_reg        <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_issue;
            if (req_take)
                rd_idx_reg <= '0;
            else if (rd_issue)
                rd_idx_reg <= rd_idx_reg + 1'b1;
            rd_lvl_valid_reg <= valid_reg[req_reg.side][rd_idx_reg];
            if (set_valid)
                valid_reg[req_reg.side][wr_idx] <= 1'b1;
            if (clr_valid)
                valid_reg[req_reg.side][wr_idx] <= 1'b0;
        end
    end

    // scan accumulators: match, first free entry, best of the other levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            found_reg      <= 1'b0;
            bp_reg         <= '0;
            bq_reg         <= '0;
        end
        else if (req_take)
        begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            found_reg      <= 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_lvl_valid_reg)
            begin
                if (mem_rdata_reg.price == req_reg.price)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_idx_reg - 1'b1;
                end
                else if (!found_reg ||
                         better(req_reg.side, mem_rdata_reg.price, bp_reg))
                begin
                    found_reg <= 1'b1;
                    bp_reg    <= mem_rdata_reg.price;
                    bq_reg    <= mem_rdata_reg.qty;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg - 1'b1;
            end
        end
    end

    // kept best per side and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_present_reg <= '0;
            best_price_reg   <= '0;
            best_qty_reg     <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (commit_go)
            begin
                best_present_reg[req_reg.side] <= nb_present;
                best_price_reg[req_reg.side]   <= nb_price;
                best_qty_reg[req_reg.side]     <= nb_qty;
                rsp_valid_reg                  <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_go)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== dv/oblt_book_checker.sv =====
// ----------------------------------------------------------------------------
// oblt_book_checker
// Watches the request and response channels of the level table, keeps its own
// copy of both book sides, predicts status and top of book for every accepted
// request beat and compares each accepted response beat field by field.
// ----------------------------------------------------------------------------
module oblt_book_checker #(
    parameter int LEVELS_PER_SIDE = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_stall,
    input  oblt_pkg::req_t  req,
    input  logic            rsp_valid,
    input  logic            rsp_stall,
    input  oblt_pkg::rsp_t  rsp,
    output int              mismatches,
    output int              outstanding
);

    localparam int BID_IDX = 0;
    localparam int ASK_IDX = 1;

    // shadow book, one row per side
    logic [31:0] shadow_price [2][LEVELS_PER_SIDE];
    logic [31:0] shadow_qty   [2][LEVELS_PER_SIDE];
    bit          shadow_live  [2][LEVELS_PER_SIDE];

    // top of book still owed by the block, oldest first
    oblt_pkg::rsp_t top_of_book_q [$];

    // update, remove or insert one level and return its status
    function automatic logic [2:0] apply_level_update(oblt_pkg::req_t r);
        int hit;
        int free_slot;
        int sd;
        int i;
        hit       = -1;
        free_slot = -1;
        sd        = (r.side == oblt_pkg::SIDE_ASK) ? ASK_IDX : BID_IDX;
        for (i = 0; i < LEVELS_PER_SIDE; i++) begin
            if (shadow_live[sd][i]) begin
                if (hit < 0 && shadow_price[sd][i] == r.price)
                    hit = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (hit >= 0) begin
            if (r.qty != 32'd0) begin
                shadow_qty[sd][hit] = r.qty;
                return oblt_pkg::STATUS_UPDATED;
            end
            shadow_live[sd][hit] = 1'b0;
            return oblt_pkg::STATUS_REMOVED;
        end
        if (r.qty == 32'd0)
            return oblt_pkg::STATUS_ZERO_ABSENT;
        if (free_slot < 0)
            return oblt_pkg::STATUS_FULL;
        shadow_price[sd][free_slot] = r.price;
        shadow_qty[sd][free_slot]   = r.qty;
        shadow_live[sd][free_slot]  = 1'b1;
        return oblt_pkg::STATUS_INSERTED;
    endfunction

    // best level of one side: highest price for bids, lowest for asks
    function automatic void best_level(input int sd, input bit want_high,
                                       output logic present,
                                       output logic [31:0] price,
                                       output logic [31:0] qty);
        int i;
        present = 1'b0;
        price   = 32'd0;
        qty     = 32'd0;
        for (i = 0; i < LEVELS_PER_SIDE; i++) begin
            if (shadow_live[sd][i] &&
                (!present || (want_high ? (shadow_price[sd][i] > price)
                                        : (shadow_price[sd][i] < price)))) begin
                present = 1'b1;
                price   = shadow_price[sd][i];
                qty     = shadow_qty[sd][i];
            end
        end
    endfunction

    function automatic oblt_pkg::rsp_t predict_book_update(oblt_pkg::req_t r);
        oblt_pkg::rsp_t res;
        res.status = apply_level_update(r);
        best_level(BID_IDX, 1'b1, res.bid_present, res.best_bid_price, res.best_bid_qty);
        best_level(ASK_IDX, 1'b0, res.ask_present, res.best_ask_price, res.best_ask_qty);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            mismatches++;
            $display("%0t: mismatch on %s: expected 0x%08h, actual 0x%08h",
                     $time, name, want, got);
        end
    endtask

    // compare response beats, then queue the prediction for a new request beat
    always @(posedge clk or negedge rst_n) begin
        oblt_pkg::rsp_t want;
        if (!rst_n) begin
            for (int sd = 0; sd < 2; sd++)
                for (int i = 0; i < LEVELS_PER_SIDE; i++)
                    shadow_live[sd][i] = 1'b0;
            top_of_book_q.delete();
            mismatches = 0;
        end else begin
            if (rsp_valid && !rsp_stall) begin
                if (top_of_book_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: mismatch: expected no response beat, actual 0x%h",
                             $time, rsp);
                end else begin
                    want = top_of_book_q.pop_front();
                    check_field("status", 32'(rsp.status), 32'(want.status));
                    check_field("bid_present", 32'(rsp.bid_present), 32'(want.bid_present));
                    check_field("best_bid_price", rsp.best_bid_price, want.best_bid_price);
                    check_field("best_bid_qty", rsp.best_bid_qty, want.best_bid_qty);
                    check_field("ask_present", 32'(rsp.ask_present), 32'(want.ask_present));
                    check_field("best_ask_price", rsp.best_ask_price, want.best_ask_price);
                    check_field("best_ask_qty", rsp.best_ask_qty, want.best_ask_qty);
                end
            end
            if (req_valid && !req_stall)
                top_of_book_q = {top_of_book_q, predict_book_update(req)};
        end
        outstanding = top_of_book_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for order_book_level_table_core. Drives a directed set
// of edge updates, then random sequences that fill a side past full, drain it,
// churn a small set of hot prices and throw in noise, with bursty requests and
// a response stall pattern. Checking is done by oblt_book_checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LEVELS_PER_SIDE  = 64;
    localparam int POOL_DEPTH       = LEVELS_PER_SIDE + 8;
    localparam int ITEM_TARGET      = 650;
    localparam int RUN_LIMIT_CYCLES = 800_000;

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    oblt_pkg::req_t  req;
    logic            rsp_valid;
    logic            rsp_stall;
    oblt_pkg::rsp_t  rsp;
    int              mismatches;
    int              outstanding;

    int          items_sent;
    int          burst_left;
    logic [31:0] price_pool [2][POOL_DEPTH];

    order_book_level_table_core #(
        .LEVELS_PER_SIDE(LEVELS_PER_SIDE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    oblt_book_checker #(
        .LEVELS_PER_SIDE(LEVELS_PER_SIDE)
    ) book_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        repeat (RUN_LIMIT_CYCLES) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // response stall pattern: free stretches, random toggling, long holds
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    rsp_stall = 1'b0;
                    repeat ($urandom_range(20, 300)) @(negedge clk);
                end
                1:
                begin
                    repeat ($urandom_range(20, 300))
                    begin
                        rsp_stall = $urandom_range(0, 1);
                        @(negedge clk);
                    end
                end
                default:
                begin
                    rsp_stall = 1'b1;
                    repeat ($urandom_range(1, 100)) @(negedge clk);
                    rsp_stall = 1'b0;
                    repeat ($urandom_range(1, 20)) @(negedge clk);
                end
            endcase
        end
    end

    function automatic int pick_burst_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    endfunction

    // nonzero quantity, extremes now and then
    function automatic logic [31:0] pick_live_qty();
        logic [31:0] q;
        case ($urandom_range(0, 9))
            0: q = 32'd1;
            1: q = 32'hFFFF_FFFF;
            default:
            begin
                q = $urandom;
                if (q == 32'd0)
                    q = 32'd1;
            end
        endcase
        return q;
    endfunction

    // distinct prices for one side: base plus a stride that cannot wrap onto itself
    task automatic refresh_price_pool(input logic side);
        logic [31:0] base;
        logic [31:0] stride;
        base   = $urandom;
        stride = $urandom_range(1, 1 << 24);
        for (int k = 0; k < POOL_DEPTH; k++)
            price_pool[side][k] = base + k * stride;
    endtask

    // one request beat, called at a falling edge, returns at a falling edge
    task automatic send_update(input logic side, input logic [31:0] price,
                               input logic [31:0] qty);
        int gap;
        req.side  = side;
        req.price = price;
        req.qty   = qty;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        items_sent++;
        @(negedge clk);
        burst_left--;
        // gap between bursts
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : $urandom_range(1, 90);
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = pick_burst_len();
        end
    endtask

    // hold off the sender until every owed response has come back
    task automatic wait_for_book_idle();
        req_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // insert the whole pool: the last entries hit a full side
    task automatic fill_side(input logic side);
        for (int k = 0; k < POOL_DEPTH; k++)
            send_update(side, price_pool[side][k], pick_live_qty());
    endtask

    // remove every pool price from a random start, then pick fresh prices
    task automatic drain_side(input logic side);
        int start;
        start = $urandom_range(0, POOL_DEPTH - 1);
        for (int k = 0; k < POOL_DEPTH; k++)
            send_update(side, price_pool[side][(start + k) % POOL_DEPTH], 32'd0);
        refresh_price_pool(side);
    endtask

    // churn on hot pool prices: updates, removes, inserts, zero for absent
    task automatic churn_levels(input int run_len);
        logic        side;
        int          idx;
        logic [31:0] qty;
        repeat (run_len)
        begin
            side = $urandom_range(0, 1) ? oblt_pkg::SIDE_ASK : oblt_pkg::SIDE_BID;
            idx  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 11)
                                               : $urandom_range(0, POOL_DEPTH - 1);
            qty  = ($urandom_range(0, 2) == 0) ? 32'd0 : pick_live_qty();
            send_update(side, price_pool[side][idx], qty);
        end
    endtask

    // fully random beats
    task automatic noise_run(input int run_len);
        logic side;
        repeat (run_len)
        begin
            side = $urandom_range(0, 1) ? oblt_pkg::SIDE_ASK : oblt_pkg::SIDE_BID;
            send_update(side, $urandom, $urandom_range(0, 1) ? $urandom : 32'd0);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        logic side;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        items_sent = 0;
        burst_left = pick_burst_len();
        refresh_price_pool(oblt_pkg::SIDE_BID);
        refresh_price_pool(oblt_pkg::SIDE_ASK);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty book, price and qty extremes, every status but full
        send_update(oblt_pkg::SIDE_BID, 32'h0000_0000, 32'h0000_0000);
        send_update(oblt_pkg::SIDE_ASK, 32'hFFFF_FFFF, 32'h0000_0000);
        send_update(oblt_pkg::SIDE_BID, 32'h0000_0000, 32'h0000_0005);
        send_update(oblt_pkg::SIDE_ASK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_update(oblt_pkg::SIDE_BID, 32'hFFFF_FFFF, 32'h0000_0001);
        send_update(oblt_pkg::SIDE_ASK, 32'h0000_0000, 32'h0000_0001);
        send_update(oblt_pkg::SIDE_BID, 32'h0000_0000, 32'hFFFF_FFFF);
        send_update(oblt_pkg::SIDE_BID, 32'hFFFF_FFFF, 32'h0000_0000);
        send_update(oblt_pkg::SIDE_ASK, 32'h0000_0000, 32'h0000_0000);
        send_update(oblt_pkg::SIDE_ASK, 32'h1234_5678, 32'h0000_0000);
        send_update(oblt_pkg::SIDE_BID, 32'h0000_0000, 32'h0000_0000);
        send_update(oblt_pkg::SIDE_ASK, 32'hFFFF_FFFF, 32'h0000_0000);
        send_update(oblt_pkg::SIDE_BID, 32'hAAAA_AAAA, 32'h5555_5555);
        send_update(oblt_pkg::SIDE_ASK, 32'h5555_5555, 32'hAAAA_AAAA);
        send_update(oblt_pkg::SIDE_BID, 32'h5555_5555, 32'hAAAA_AAAA);
        send_update(oblt_pkg::SIDE_ASK, 32'hAAAA_AAAA, 32'h5555_5555);
        send_update(oblt_pkg::SIDE_BID, 32'hAAAA_AAAA, 32'h0000_0000);
        send_update(oblt_pkg::SIDE_ASK, 32'h5555_5555, 32'h0000_0000);
        wait_for_book_idle();

        // both sides driven past full early on
        fill_side(oblt_pkg::SIDE_BID);
        churn_levels(20);
        fill_side(oblt_pkg::SIDE_ASK);
        wait_for_book_idle();

        // random sequences
        while (items_sent < ITEM_TARGET)
        begin
            side = $urandom_range(0, 1) ? oblt_pkg::SIDE_ASK : oblt_pkg::SIDE_BID;
            case ($urandom_range(0, 9))
                0:       fill_side(side);
                1:       drain_side(side);
                2:       noise_run($urandom_range(1, 5));
                default: churn_levels($urandom_range(10, 40));
            endcase
        end

        // drain and settle
        wait_for_book_idle();
        repeat (LEVELS_PER_SIDE + 3) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/oblt_pkg.sv
hw/rtl/order_book_level_table_core.sv
dv/oblt_book_checker.sv
dv/tb_top.sv
